// ===== sv/satr_pkg.sv =====
// Shared types and codes for the smart card ATR parser.
// No dependencies; imported by every module of the parser.
`default_nettype none

package satr_pkg;

   // Field kind codes reported with each result item
   localparam logic [2:0] KIND_TS     = 3'd0;
   localparam logic [2:0] KIND_T0     = 3'd1;
   localparam logic [2:0] KIND_IFACE  = 3'd2;
   localparam logic [2:0] KIND_HIST   = 3'd3;
   localparam logic [2:0] KIND_CHECK  = 3'd4;
   localparam logic [2:0] KIND_BEYOND = 3'd5;
   localparam logic [2:0] KIND_ERROR  = 3'd6;

   localparam logic [7:0] TS_INVERSE_RAW = 8'h03;
   localparam logic [7:0] TS_INVERSE_OUT = 8'h3F;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       new_atr;
   } satr_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [5:0] byte_index;
      logic [2:0] field_kind;
      logic       atr_complete;
      logic [3:0] protocol;
      logic       inverse;
      logic       overflow;
   } satr_rsp_type;

endpackage

`default_nettype wire

// ===== sv/satr_parse.sv =====
// ATR structure tracker: parse state and the result register.
// Depends on satr_pkg; driven by the input stage of smart_card_atr_parser.
`default_nettype none

module satr_parse
   import satr_pkg::*;
#(
   parameter int MAX_ATR_BYTES = 33
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         advance,
   input  wire satr_req_type item,
   input  wire logic         rsp_ready,
   output logic              rsp_valid,
   output satr_rsp_type      rsp_item
);

   typedef enum logic [2:0] {
      PH_WAIT_TS = 3'd0,
      PH_T0      = 3'd1,
      PH_IFACE   = 3'd2,
      PH_HIST    = 3'd3,
      PH_CHECK   = 3'd4,
      PH_DONE    = 3'd5,
      PH_ERROR   = 3'd6
   } phase_type;

   localparam logic [5:0] MAX_BYTES = 6'(MAX_ATR_BYTES);

   phase_type    phase_ff, phase_in;
   logic [2:0]   group_left_ff, group_left_in;
   logic         td_follows_ff, td_follows_in;
   logic [3:0]   hist_left_ff, hist_left_in;
   logic [3:0]   protocol_ff, protocol_in;
   logic         inverse_ff, inverse_in;
   logic [5:0]   byte_count_ff, byte_count_in;
   logic         rsp_valid_ff, rsp_valid_in;
   satr_rsp_type rsp_ff, rsp_in;

   logic [7:0]   decoded;
   logic [7:0]   c;
   logic [2:0]   pop;
   logic [2:0]   group_dec;
   logic         complete;
   logic [2:0]   kind;
   logic [5:0]   index;
   logic         settle_req;

   // Inverse convention: reverse bit order and invert
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         decoded[7 - i] = ~item.rx_byte[i];
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      group_left_in = group_left_ff;
      td_follows_in = td_follows_ff;
      hist_left_in  = hist_left_ff;
      protocol_in   = protocol_ff;
      inverse_in    = inverse_ff;
      byte_count_in = byte_count_ff;
      c             = inverse_ff ? decoded : item.rx_byte;
      index         = byte_count_ff;
      kind          = KIND_ERROR;
      complete      = 1'b0;
      settle_req    = 1'b0;
      pop           = 3'({2'b00, c[4]} + {2'b00, c[5]} + {2'b00, c[6]} + {2'b00, c[7]});
      group_dec     = (group_left_ff != 3'd0) ? group_left_ff - 3'd1 : group_left_ff;

      priority if (item.new_atr || phase_ff == PH_WAIT_TS) begin
         inverse_in    = (item.rx_byte == TS_INVERSE_RAW);
         c             = inverse_in ? TS_INVERSE_OUT : item.rx_byte;
         group_left_in = 3'd0;
         td_follows_in = 1'b0;
         hist_left_in  = 4'd0;
         protocol_in   = 4'd0;
         index         = 6'd0;
         kind          = KIND_TS;
         byte_count_in = 6'd1;
         phase_in      = PH_T0;
      end else if (phase_ff == PH_DONE) begin
         kind = KIND_BEYOND;
      end else if (phase_ff == PH_ERROR || phase_ff > PH_ERROR
                   || byte_count_ff >= MAX_BYTES) begin
         phase_in = PH_ERROR;
         kind     = KIND_ERROR;
      end else begin
         byte_count_in = byte_count_ff + 6'd1;
         unique case (phase_ff)
            PH_T0: begin
               kind          = KIND_T0;
               hist_left_in  = c[3:0];
               group_left_in = pop;
               td_follows_in = c[7];
               settle_req    = 1'b1;
            end
            PH_IFACE: begin
               kind          = KIND_IFACE;
               group_left_in = group_dec;
               // last byte of a group that carried TD: chain to the next group
               if (group_dec == 3'd0 && td_follows_ff) begin
                  protocol_in   = c[3:0];
                  group_left_in = pop;
                  td_follows_in = c[7];
               end
               settle_req = 1'b1;
            end
            PH_HIST: begin
               kind         = KIND_HIST;
               hist_left_in = (hist_left_ff != 4'd0) ? hist_left_ff - 4'd1 : hist_left_ff;
               settle_req   = 1'b1;
            end
            default: begin
               kind     = KIND_CHECK;
               phase_in = PH_DONE;
               complete = 1'b1;
            end
         endcase
      end

      if (settle_req) begin
         priority if (group_left_in != 3'd0) begin
            phase_in = PH_IFACE;
         end else if (hist_left_in != 4'd0) begin
            phase_in = PH_HIST;
         end else if (protocol_in != 4'd0) begin
            phase_in = PH_CHECK;
         end else begin
            phase_in = PH_DONE;
            complete = 1'b1;
         end
      end

      rsp_in.out_byte     = c;
      rsp_in.byte_index   = index;
      rsp_in.field_kind   = kind;
      rsp_in.atr_complete = complete;
      rsp_in.protocol     = protocol_in;
      rsp_in.inverse      = inverse_in;
      rsp_in.overflow     = (phase_in == PH_ERROR);

      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_WAIT_TS;
         group_left_ff <= 3'd0;
         td_follows_ff <= 1'b0;
         hist_left_ff  <= 4'd0;
         protocol_ff   <= 4'd0;
         inverse_ff    <= 1'b0;
         byte_count_ff <= 6'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            phase_ff      <= phase_in;
            group_left_ff <= group_left_in;
            td_follows_ff <= td_follows_in;
            hist_left_ff  <= hist_left_in;
            protocol_ff   <= protocol_in;
            inverse_ff    <= inverse_in;
            byte_count_ff <= byte_count_in;
         end
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// ===== sv/smart_card_atr_parser.sv =====
// Top level of the smart card ATR parser: input register and handshake.
// Depends on satr_pkg and satr_parse.
`default_nettype none

// Takes one received ATR byte per item and returns one result item per byte:
// the convention-corrected byte, its position, its field kind, the
// completion flag, the latest TD protocol and the inverse/overflow flags.
// One item per clock cycle is sustained while the result side is not
// stalled; each item passes the input register and then the result
// register before its result is presented. A new byte is taken while a
// finished result waits, as long as the input register can move on.
// new_atr restarts parsing at any point and clears an overflow.

module smart_card_atr_parser
   import satr_pkg::*;
#(
   parameter int MAX_ATR_BYTES = 33
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire satr_req_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output satr_rsp_type      rsp_item
);

   satr_req_type req_ff;
   logic         req_valid_ff, req_valid_in;
   logic         advance;

   // move the held item on when the result register is free or draining
   assign advance      = req_valid_ff && (!rsp_valid || rsp_ready);
   assign req_ready    = !req_valid_ff || advance;
   assign req_valid_in = (req_valid && req_ready) || (req_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      if (req_valid && req_ready) begin
         req_ff <= req_item;
      end
   end

   satr_parse #(
      .MAX_ATR_BYTES (MAX_ATR_BYTES)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .item      (req_ff),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

// ===== sv/satr_checker.sv =====
// Port-level checks for smart_card_atr_parser, attached by bind.
// Depends on satr_pkg.
`default_nettype none

module satr_checker
   import satr_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire satr_rsp_type rsp_item
);

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result item changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.field_kind == KIND_TS |-> rsp_item.byte_index == 6'd0)
      else $error("TS item not at position zero");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.overflow |-> rsp_item.field_kind == KIND_ERROR)
      else $error("overflow without error kind");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.atr_complete |->
         rsp_item.field_kind == KIND_T0 || rsp_item.field_kind == KIND_IFACE ||
         rsp_item.field_kind == KIND_HIST || rsp_item.field_kind == KIND_CHECK)
      else $error("completion flagged on wrong field kind");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.field_kind == KIND_TS && rsp_item.inverse |->
         rsp_item.out_byte == TS_INVERSE_OUT)
      else $error("inverse TS not reported as 0x3F");

endmodule

bind smart_card_atr_parser satr_checker u_satr_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

`default_nettype wire
